// ===== hw/rtl/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types, constants and the search-step update for the FPN corrector.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int PIX_W   = 12;
  localparam int SEG_W   = 6;
  localparam int CNT_W   = 7;
  localparam int ADDR_W  = PIX_W + SEG_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int MAX_SEGMENTS = 1 << SEG_W;
  localparam int SEARCH_STEPS = SEG_W;

  localparam logic [1:0] CMD_CORRECT = 2'd0;
  localparam logic [1:0] CMD_REF     = 2'd1;
  localparam logic [1:0] CMD_SCALE   = 2'd2;
  localparam logic [1:0] CMD_OFFSET  = 2'd3;

  localparam logic [1:0] CLIP_NONE = 2'd0;
  localparam logic [1:0] CLIP_HIGH = 2'd1;
  localparam logic [1:0] CLIP_LOW  = 2'd2;

  localparam logic CFG_SEG_COUNT = 1'b0;
  localparam logic CFG_ENABLE    = 1'b1;

  typedef struct packed {
    logic             vld;
    logic [1:0]       cmd;
    logic [PIX_W-1:0] pix;
    logic [15:0]      p;
    logic [SEG_W-1:0] slot;
    logic [31:0]      tv;
    logic             en;
    logic             srch;
    logic [SEG_W-1:0] low;
    logic [CNT_W-1:0] up;
    logic [SEG_W-1:0] mid;
  } item_t;

  // Narrow the interval around mid, then pick the next probe.
  function automatic item_t step_update(item_t it, logic [15:0] level);
    item_t      r;
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] nmid;
    r = it;
    if (it.srch) begin
      if (it.p < level) r.up = {1'b0, it.mid};
      else r.low = it.mid;
    end
    span   = r.up - {1'b0, r.low};
    nmid   = {1'b0, r.low} + (span >> 1);
    r.mid  = nmid[SEG_W-1:0];
    r.srch = (span > 7'd1);
    return r;
  endfunction

endpackage

// ===== hw/rtl/plc_search_step.sv =====
// ----------------------------------------------------------------------------
// plc_search_step
// One binary-search step: own copy of the reference levels, one probe read.
// ----------------------------------------------------------------------------
module plc_search_step (
  input  logic           clk,
  input  logic           rst,
  input  plc_pkg::item_t in_item,
  output plc_pkg::item_t out_item
);

  logic [15:0] mem [plc_pkg::DEPTH];
  logic [15:0] rdata;
  plc_pkg::item_t q;

  // Writes ride the pipe so each copy sees them in request order.
  always_ff @(posedge clk) begin
    if (in_item.vld && in_item.cmd == plc_pkg::CMD_REF) begin
      mem[{in_item.pix, in_item.slot}] <= in_item.tv[15:0];
    end
    rdata <= mem[{in_item.pix, in_item.mid}];
  end

  always_ff @(posedge clk) begin
    q <= in_item;
    if (rst) begin
      q.vld <= 1'b0;
    end
  end

  assign out_item = plc_pkg::step_update(q, rdata);

endmodule

// ===== hw/rtl/plc_coef_stage.sv =====
// ----------------------------------------------------------------------------
// plc_coef_stage
// Scale and offset tables; fetch the chosen segment's coefficients.
// ----------------------------------------------------------------------------
module plc_coef_stage (
  input  logic           clk,
  input  logic           rst,
  input  plc_pkg::item_t in_item,
  output plc_pkg::item_t out_item,
  output logic [23:0]    scale,
  output logic [31:0]    offset
);

  logic [23:0] scale_mem  [plc_pkg::DEPTH];
  logic [31:0] offset_mem [plc_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (in_item.vld && in_item.cmd == plc_pkg::CMD_SCALE) begin
      scale_mem[{in_item.pix, in_item.slot}] <= in_item.tv[23:0];
    end
    scale <= scale_mem[{in_item.pix, in_item.low}];
  end

  always_ff @(posedge clk) begin
    if (in_item.vld && in_item.cmd == plc_pkg::CMD_OFFSET) begin
      offset_mem[{in_item.pix, in_item.slot}] <= in_item.tv;
    end
    offset <= offset_mem[{in_item.pix, in_item.low}];
  end

  always_ff @(posedge clk) begin
    out_item <= in_item;
    if (rst) begin
      out_item.vld <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/plc_arith.sv =====
// ----------------------------------------------------------------------------
// plc_arith
// Multiply, add offset, truncate toward zero, clamp, register the result.
// ----------------------------------------------------------------------------
module plc_arith (
  input  logic           clk,
  input  logic           rst,
  input  plc_pkg::item_t in_item,
  input  logic [23:0]    scale,
  input  logic [31:0]    offset,
  output logic           done,
  output logic [15:0]    corrected_value,
  output logic [5:0]     segment_used,
  output logic [1:0]     clip_kind
);

  plc_pkg::item_t a_item, b_item;
  logic signed [40:0] prod;
  logic signed [31:0] a_off;
  logic signed [49:0] acc;
  logic signed [33:0] quo;
  logic signed [33:0] res;
  logic [15:0] val_next;
  logic [1:0]  clip_next;

  // Stage A: product
  always_ff @(posedge clk) begin
    prod   <= $signed({1'b0, in_item.p}) * $signed(scale);
    a_off  <= $signed(offset);
    a_item <= in_item;
    if (rst) begin
      a_item.vld <= 1'b0;
    end
  end

  // Stage B: add offset in Q.16
  always_ff @(posedge clk) begin
    acc    <= 50'(prod) + {{2{a_off[31]}}, a_off, 16'd0};
    b_item <= a_item;
    if (rst) begin
      b_item.vld <= 1'b0;
    end
  end

  always_comb begin
    quo = acc[49:16];
    if (acc[49] && acc[15:0] != 16'd0) res = quo + 34'sd1;
    else res = quo;
    if (res > 34'sd65535) begin
      val_next  = 16'hFFFF;
      clip_next = plc_pkg::CLIP_HIGH;
    end else if (res < 34'sd0) begin
      val_next  = 16'd0;
      clip_next = plc_pkg::CLIP_LOW;
    end else begin
      val_next  = res[15:0];
      clip_next = plc_pkg::CLIP_NONE;
    end
  end

  // Stage C: result; only correct requests produce a strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b_item.vld && b_item.cmd == plc_pkg::CMD_CORRECT;
    end
    if (b_item.en) begin
      corrected_value <= val_next;
      segment_used    <= b_item.low;
      clip_kind       <= clip_next;
    end else begin
      corrected_value <= b_item.p;
      segment_used    <= '0;
      clip_kind       <= plc_pkg::CLIP_NONE;
    end
  end

endmodule

// ===== hw/rtl/fpn_piecewise_linear_correct_unit.sv =====
// ----------------------------------------------------------------------------
// fpn_piecewise_linear_correct_unit
// Per-pixel piecewise-linear fixed-pattern-noise correction, fully pipelined.
// ----------------------------------------------------------------------------
// The unit takes one request per clock (busy stays low) and never stalls:
// a correct request raises done from the result register at the end of the
// pipe. The entry register loads at the edge that takes it, then six search
// steps, the coefficient read, multiply, add and result register follow in
// that order. Table writes give no result. Each search step owns a copy of the
// reference-level table so every stage probes once per cycle, and table
// writes travel down the pipe, so each table copy sees reads and writes in
// request order. Tables are not cleared: read only written entries.
// ----------------------------------------------------------------------------
module fpn_piecewise_linear_correct_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [11:0] pixel_index,
  input  logic [15:0] pixel_value,
  input  logic [5:0]  table_slot,
  input  logic [31:0] table_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        done,
  output logic [15:0] corrected_value,
  output logic [5:0]  segment_used,
  output logic [1:0]  clip_kind
);

  logic [6:0] segment_count;
  logic       correction_enable;
  logic [6:0] cnt;
  plc_pkg::item_t entry, entry_next;
  plc_pkg::item_t chain [plc_pkg::SEARCH_STEPS+1];
  plc_pkg::item_t coef_item;
  logic [23:0] scale;
  logic [31:0] offset;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count     <= 7'd1;
      correction_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        plc_pkg::CFG_SEG_COUNT: segment_count     <= cfg_data;
        plc_pkg::CFG_ENABLE:    correction_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Zero acts as one segment, anything above the table size as the maximum.
  always_comb begin
    if (segment_count == 7'd0) cnt = 7'd1;
    else if (segment_count > 7'(plc_pkg::MAX_SEGMENTS)) cnt = 7'(plc_pkg::MAX_SEGMENTS);
    else cnt = segment_count;
  end

  // Seed the search interval [0, count)
  always_comb begin
    entry_next.vld  = start && !busy;
    entry_next.cmd  = command;
    entry_next.pix  = pixel_index;
    entry_next.p    = pixel_value;
    entry_next.slot = table_slot;
    entry_next.tv   = table_value;
    entry_next.en   = correction_enable;
    entry_next.low  = '0;
    entry_next.up   = cnt;
    entry_next.mid  = 6'(cnt >> 1);
    entry_next.srch = (cnt > 7'd1);
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (rst) begin
      entry.vld <= 1'b0;
    end
  end

  assign chain[0] = entry;

  for (genvar k = 0; k < plc_pkg::SEARCH_STEPS; k++) begin : g_step
    plc_search_step u_step (
      .clk      (clk),
      .rst      (rst),
      .in_item  (chain[k]),
      .out_item (chain[k+1])
    );
  end

  plc_coef_stage u_coef (
    .clk      (clk),
    .rst      (rst),
    .in_item  (chain[plc_pkg::SEARCH_STEPS]),
    .out_item (coef_item),
    .scale    (scale),
    .offset   (offset)
  );

  plc_arith u_arith (
    .clk             (clk),
    .rst             (rst),
    .in_item         (coef_item),
    .scale           (scale),
    .offset          (offset),
    .done            (done),
    .corrected_value (corrected_value),
    .segment_used    (segment_used),
    .clip_kind       (clip_kind)
  );

  a_clip_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (clip_kind == plc_pkg::CLIP_NONE || clip_kind == plc_pkg::CLIP_HIGH ||
              clip_kind == plc_pkg::CLIP_LOW))
    else $error("bad clip code");

  a_clip_high: assert property (@(posedge clk) disable iff (rst)
    (done && clip_kind == plc_pkg::CLIP_HIGH) |-> corrected_value == 16'hFFFF)
    else $error("clipped high but value not full scale");

  a_clip_low: assert property (@(posedge clk) disable iff (rst)
    (done && clip_kind == plc_pkg::CLIP_LOW) |-> corrected_value == 16'd0)
    else $error("clipped low but value not zero");

endmodule

// ===== sim/tb_fpn_piecewise_linear_correct_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fpn_piecewise_linear_correct_unit
// Self-checking bench for the per-pixel piecewise-linear FPN corrector. It
// fills the tables of a few pixels fully, then corrects only those pixels, so
// no unwritten entry is ever read. Each correct request is checked against
// its directed-row result or an in-bench model of the search, multiply, add
// and clamp. A directed table comes first, then randomized phases with new settings.
// ----------------------------------------------------------------------------
module tb_fpn_piecewise_linear_correct_unit;

  // Pipeline depth from request to done, and the idle hold-off used before
  // touching configuration (writes give no done, so they may still be in
  // flight once the queue is empty).
  localparam int LATENCY  = 10;
  localparam int HOLD_OFF = LATENCY + 5;
  localparam int NUM_HOT  = 4;

  typedef struct {
    logic [15:0] value;
    logic [5:0]  segment;
    logic [1:0]  clip;
  } pixel_result_t;

  // One row of the directed table; exp_* is only used when has_exp is set.
  typedef struct {
    logic [1:0]  cmd;
    logic [11:0] pix;
    logic [15:0] val;
    logic [5:0]  slot;
    logic [31:0] tv;
    logic        en;
    logic        has_exp;
    logic [15:0] exp_val;
    logic [5:0]  exp_seg;
    logic [1:0]  exp_clip;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = plc_pkg::CMD_CORRECT;
  logic [11:0] pixel_index = '0;
  logic [15:0] pixel_value = '0;
  logic [5:0]  table_slot = '0;
  logic [31:0] table_value = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = plc_pkg::CFG_SEG_COUNT;
  logic [6:0]  cfg_data = '0;
  logic        done;
  logic [15:0] corrected_value;
  logic [5:0]  segment_used;
  logic [1:0]  clip_kind;

  // Shadow copy of the block's tables and settings.
  logic [15:0]        level_mem  [0:plc_pkg::DEPTH-1];
  logic signed [23:0] scale_mem  [0:plc_pkg::DEPTH-1];
  logic signed [31:0] offset_mem [0:plc_pkg::DEPTH-1];
  logic [6:0]         seg_count_cfg = 7'd1;
  logic               enable_cfg = 1'b0;

  pixel_result_t pending_results[$];
  logic [11:0]   hot_pixels[NUM_HOT];
  int            errors = 0;

  fpn_piecewise_linear_correct_unit dut (.*);

  always #5 clk = ~clk;

  // Search the pixel's levels, then apply scale and offset and clamp.
  function automatic pixel_result_t correct_pixel(logic [11:0] pix, logic [15:0] p);
    pixel_result_t r;
    int            cnt;
    int            lo;
    int            hi;
    int            mid;
    int            base;
    longint        acc;
    longint        q;
    base = int'(pix) * plc_pkg::MAX_SEGMENTS;
    if (!enable_cfg) begin
      r.value = p;
      r.segment = '0;
      r.clip = plc_pkg::CLIP_NONE;
      return r;
    end
    cnt = int'(seg_count_cfg);
    if (cnt < 1) cnt = 1;
    if (cnt > plc_pkg::MAX_SEGMENTS) cnt = plc_pkg::MAX_SEGMENTS;
    lo = 0;
    hi = cnt;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (p < level_mem[base + mid]) hi = mid;
      else lo = mid;
    end
    acc = longint'(p) * longint'(scale_mem[base + lo])
        + longint'(offset_mem[base + lo]) * 64'sd65536;
    q = acc / 64'sd65536;   // truncates toward zero
    r.segment = lo[5:0];
    if (q > 65535) begin
      r.value = 16'hFFFF;
      r.clip = plc_pkg::CLIP_HIGH;
    end else if (q < 0) begin
      r.value = '0;
      r.clip = plc_pkg::CLIP_LOW;
    end else begin
      r.value = q[15:0];
      r.clip = plc_pkg::CLIP_NONE;
    end
    return r;
  endfunction

  // Issue one request: idle a random gap, then hold start until taken.
  // On acceptance, update the shadow tables or queue the expected result.
  task automatic send_request(logic [1:0] cmd, logic [11:0] pix, logic [15:0] val,
                              logic [5:0] slot, logic [31:0] tv,
                              bit use_given, pixel_result_t given);
    int gap;
    int addr;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    pixel_index <= pix;
    pixel_value <= val;
    table_slot  <= slot;
    table_value <= tv;
    do @(posedge clk); while (!(start && !busy));
    addr = int'(pix) * plc_pkg::MAX_SEGMENTS + int'(slot);
    case (cmd)
      plc_pkg::CMD_CORRECT:
        pending_results.push_back(use_given ? given : correct_pixel(pix, val));
      plc_pkg::CMD_REF:   level_mem[addr] = tv[15:0];
      plc_pkg::CMD_SCALE: scale_mem[addr] = tv[23:0];
      default:            offset_mem[addr] = tv;
    endcase
  endtask

  // Drop start, drain the pipe, then write one register.
  task automatic write_register(logic idx, logic [6:0] data);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == plc_pkg::CFG_SEG_COUNT) seg_count_cfg = data;
    else enable_cfg = data[0];
  endtask

  // Scale near 1.0 most of the time so results land in range; else extremes or random.
  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 9))
      0:       return 32'h007FFFFF;
      1:       return 32'hFF800000;
      2:       return $urandom;
      default: return 32'(65536 + int'($urandom_range(0, 32767)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2:       return $urandom;
      default: return 32'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [31:0] pick_level(logic [5:0] slot);
    if ($urandom_range(0, 9) < 8)
      return 32'(int'(slot) * 1024 + int'($urandom_range(0, 1023)));
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_pixel_value();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Check each done pulse against the oldest expectation.
  always @(posedge clk) begin
    pixel_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d segment %0d clip %0d",
               corrected_value, segment_used, clip_kind);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (corrected_value !== e.value) begin
          $error("corrected_value: expected %0d, got %0d", e.value, corrected_value);
          errors++;
        end
        if (segment_used !== e.segment) begin
          $error("segment_used: expected %0d, got %0d", e.segment, segment_used);
          errors++;
        end
        if (clip_kind !== e.clip) begin
          $error("clip_kind: expected %0d, got %0d", e.clip, clip_kind);
          errors++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    directed_row_t rows[$];
    pixel_result_t given;
    pixel_result_t none;
    logic [6:0]    counts[8];
    logic [11:0]   pix;
    logic [5:0]    slot;
    logic [1:0]    cmd;
    int            n;

    none = '{value: '0, segment: '0, clip: plc_pkg::CLIP_NONE};
    // Hot pixels cover both ends of the index range.
    hot_pixels[0] = 12'd0;
    hot_pixels[1] = 12'hFFF;
    hot_pixels[2] = 12'($urandom_range(1, 2047));
    hot_pixels[3] = 12'($urandom_range(2048, 4094));

    // Hold reset once, at the start.
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every slot of every hot pixel; levels rise with the slot.
    for (int h = 0; h < NUM_HOT; h++) begin
      for (int s = 0; s < plc_pkg::MAX_SEGMENTS; s++) begin
        send_request(plc_pkg::CMD_REF, hot_pixels[h], '0, 6'(s),
                     32'(s * 1024 + int'($urandom_range(0, 1023))), 0, none);
        send_request(plc_pkg::CMD_SCALE, hot_pixels[h], '0, 6'(s), pick_scale(), 0, none);
        send_request(plc_pkg::CMD_OFFSET, hot_pixels[h], '0, 6'(s), pick_offset(), 0, none);
      end
    end

    // Directed table, one segment in use. Pass-through rows first, then clamp high,
    // small negative, clamp low and identity on the top pixel; extremes on pixel 0.
    rows = '{
      '{plc_pkg::CMD_CORRECT, 12'd0,   16'd0,     6'd0,  32'd0,
        1'b0, 1'b1, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_CORRECT, 12'hFFF, 16'hFFFF,  6'd0,  32'd0,
        1'b0, 1'b1, 16'hFFFF,  6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_CORRECT, 12'hFFF, 16'hAAAA,  6'd0,  32'd0,
        1'b0, 1'b1, 16'hAAAA,  6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_SCALE,   12'hFFF, 16'd0,     6'd0,  32'h007FFFFF,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_OFFSET,  12'hFFF, 16'd0,     6'd0,  32'd0,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_CORRECT, 12'hFFF, 16'hFFFF,  6'd0,  32'd0,
        1'b1, 1'b1, 16'hFFFF,  6'd0, plc_pkg::CLIP_HIGH},
      '{plc_pkg::CMD_CORRECT, 12'hFFF, 16'd0,     6'd0,  32'd0,
        1'b1, 1'b1, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_SCALE,   12'hFFF, 16'd0,     6'd0,  32'hFFFFFFFF,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_CORRECT, 12'hFFF, 16'd1,     6'd0,  32'd0,
        1'b1, 1'b1, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_CORRECT, 12'hFFF, 16'hFFFF,  6'd0,  32'd0,
        1'b1, 1'b1, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_SCALE,   12'hFFF, 16'd0,     6'd0,  32'd0,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_OFFSET,  12'hFFF, 16'd0,     6'd0,  32'hFFFFFFFF,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_CORRECT, 12'hFFF, 16'd777,   6'd0,  32'd0,
        1'b1, 1'b1, 16'd0,     6'd0, plc_pkg::CLIP_LOW},
      '{plc_pkg::CMD_SCALE,   12'hFFF, 16'd0,     6'd0,  32'h00010000,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_OFFSET,  12'hFFF, 16'd0,     6'd0,  32'd0,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_CORRECT, 12'hFFF, 16'd12345, 6'd0,  32'd0,
        1'b1, 1'b1, 16'd12345, 6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_SCALE,   12'd0,   16'd0,     6'd0,  32'h00800000,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_OFFSET,  12'd0,   16'd0,     6'd0,  32'h7FFFFFFF,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_CORRECT, 12'd0,   16'hFFFF,  6'd0,  32'd0,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_OFFSET,  12'd0,   16'd0,     6'd0,  32'h80000000,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_CORRECT, 12'd0,   16'hFFFF,  6'd0,  32'd0,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_REF,     12'd0,   16'd0,     6'd63, 32'hFFFFFFFF,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE},
      '{plc_pkg::CMD_OFFSET,  12'd0,   16'd0,     6'd63, 32'd5,
        1'b1, 1'b0, 16'd0,     6'd0, plc_pkg::CLIP_NONE}
    };
    foreach (rows[i]) begin
      if (rows[i].en != enable_cfg) write_register(plc_pkg::CFG_ENABLE, {6'd0, rows[i].en});
      given = '{value: rows[i].exp_val, segment: rows[i].exp_seg, clip: rows[i].exp_clip};
      send_request(rows[i].cmd, rows[i].pix, rows[i].val, rows[i].slot, rows[i].tv,
                   rows[i].has_exp, given);
    end

    // Random phases; counts include the clamped extremes zero and 127.
    counts = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd33, 7'd64, 7'd0};
    counts[4] = 7'($urandom_range(2, 63));
    for (int ph = 0; ph < 8; ph++) begin
      write_register(plc_pkg::CFG_SEG_COUNT, counts[ph]);
      write_register(plc_pkg::CFG_ENABLE, (ph == 5) ? 7'd0 : 7'd1);
      n = (ph == 7) ? 50 : 80;
      for (int k = 0; k < n; k++) begin
        pix  = hot_pixels[$urandom_range(0, NUM_HOT - 1)];
        slot = 6'($urandom);
        if ($urandom_range(0, 99) < 55) begin
          send_request(plc_pkg::CMD_CORRECT, pix, pick_pixel_value(), slot, $urandom, 0, none);
        end else begin
          cmd = 2'($urandom_range(1, 3));
          // Writes elsewhere are read back only if they hit a hot pixel; they exercise the index.
          if ($urandom_range(0, 4) == 0) begin
            send_request(cmd, 12'($urandom), 16'($urandom), slot, $urandom, 0, none);
          end else begin
            case (cmd)
              plc_pkg::CMD_REF:
                send_request(cmd, pix, 16'($urandom), slot, pick_level(slot), 0, none);
              plc_pkg::CMD_SCALE:
                send_request(cmd, pix, 16'($urandom), slot, pick_scale(), 0, none);
              default:
                send_request(cmd, pix, 16'($urandom), slot, pick_offset(), 0, none);
            endcase
          end
        end
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/plc_pkg.sv
hw/rtl/plc_search_step.sv
hw/rtl/plc_coef_stage.sv
hw/rtl/plc_arith.sv
hw/rtl/fpn_piecewise_linear_correct_unit.sv
sim/tb_fpn_piecewise_linear_correct_unit.sv
